FILE: src/rctrgq_pkg.sv
// Package for the RC-timing ratio gear quantizer.
// Holds item types, state encoding, widths, gear thresholds and LED pattern.
// No dependencies.
`default_nettype none

package rctrgq_pkg;

  localparam int TimeBits  = 8;
  localparam int ScaleW    = 8;
  localparam int RatioW    = 8;
  localparam int GearW     = 4;
  localparam int CfgIdxW   = 8;
  localparam int CfgDataW  = 8;

  localparam int SumW      = 12;
  localparam int SeedShift = 3;
  localparam int DivW      = SumW - SeedShift;
  localparam int DvdW      = DivW + ScaleW;
  localparam int StepW     = $clog2(DvdW + 1);

  localparam logic [SumW-1:0]    SumMax   = {SumW{1'b1}};
  localparam logic [RatioW-1:0]  RatioMax = {RatioW{1'b1}};

  localparam logic [CfgIdxW-1:0] RegRatioScale = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] RegSelfTest   = CfgIdxW'(1);

  localparam logic [ScaleW-1:0]  ScaleReset    = ScaleW'(230);

  localparam int NumFloors = 10;
  localparam logic [RatioW-1:0] GearFloor [NumFloors] = '{
    8'd227, 8'd206, 8'd173, 8'd155, 8'd125, 8'd103, 8'd75, 8'd56, 8'd22, 8'd5
  };

  typedef struct packed {
    logic [TimeBits-1:0] ref_time;
    logic [TimeBits-1:0] pot_time;
  } in_item_t;

  typedef struct packed {
    logic [RatioW-1:0] ratio;
    logic [GearW-1:0]  gear;
    logic              led_update;
    logic              led_first;
    logic              led_second;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_FIN
  } state_t;

  // Lowest-numbered gear whose floor the ratio reaches; 11 below the last floor.
  function automatic logic [GearW-1:0] gear_of(input logic [RatioW-1:0] ratio);
    logic [GearW-1:0] g;
    g = GearW'(NumFloors + 1);
    for (int i = NumFloors - 1; i >= 0; i--) begin
      if (ratio >= GearFloor[i]) begin
        g = GearW'(i + 1);
      end
    end
    return g;
  endfunction

  // Three-step LED cycle starting at gear 1: (1,1), (1,0), (0,0).
  function automatic logic [1:0] leds_of(input logic [GearW-1:0] gear);
    logic [1:0] l;
    case (gear) inside
      4'd1, 4'd4, 4'd7, 4'd10: l = 2'b11;
      4'd2, 4'd5, 4'd8, 4'd11: l = 2'b10;
      default:                 l = 2'b00;
    endcase
    return l;
  endfunction

endpackage

`default_nettype wire

FILE: src/rc_timing_ratio_gear_quantizer.sv
// RC-timing ratio gear quantizer: accumulates measured pairs, then forms a
// saturated scaled ratio with a multiply and a shared restoring divider.
// Depends on rctrgq_pkg.
// An item that does not close a round is taken while in_ready stays high.
// The closing item's result passes through a multiply, 17 divider steps
// through one subtractor and a quantize/load; ready is low then,
// longer while an earlier result still holds the output register.
// No item of the next round is taken until the result is loaded into the output register.
// Output register lets the next round accumulate while a result waits.
// Sync active-low reset clears sums, pair count, output valid and sets
// ratio_scale to 230, self_test to 0.
`default_nettype none

module rc_timing_ratio_gear_quantizer
  import rctrgq_pkg::*;
#(
  parameter int PAIRS_PER_RESULT = 8
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output      logic                in_ready,
  input  wire in_item_t            in_data,
  output      logic                out_valid,
  input  wire logic                out_ready,
  output      out_item_t           out_data,
  input  wire logic                cfg_valid,
  output      logic                cfg_ready,
  input  wire logic [CfgIdxW-1:0]  cfg_index,
  input  wire logic [CfgDataW-1:0] cfg_data
);

  localparam int CntW = $clog2(PAIRS_PER_RESULT);
  localparam logic [CntW-1:0] CntLast = CntW'(PAIRS_PER_RESULT - 1);
  localparam logic [StepW-1:0] StepLast = StepW'(DvdW - 1);

  state_t            state_r, state_nxt;
  logic [SumW-1:0]   ref_sum_r, ref_sum_nxt;
  logic [SumW-1:0]   pot_sum_r, pot_sum_nxt;
  logic [CntW-1:0]   cnt_r, cnt_nxt;
  logic [StepW-1:0]  step_r, step_nxt;
  logic [DivW-1:0]   rem_r, rem_nxt;
  logic [DvdW-1:0]   dvd_r, dvd_nxt;
  logic [ScaleW-1:0] scale_r;
  logic              self_test_r;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_data_r, out_data_nxt;

  logic              in_fire;
  logic              out_free;
  logic [SumW:0]     ref_add, pot_add;
  logic [SumW-1:0]   ref_sat, pot_sat;
  logic [DivW:0]     trial;
  logic [DivW+1:0]   diff;
  logic [RatioW-1:0] ratio_q;
  logic [GearW-1:0]  gear_q;
  logic [1:0]        leds_q;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_free  = !out_valid_r || out_ready;
  assign cfg_ready = 1'b1;

  assign ref_add = {1'b0, ref_sum_r} + (SumW+1)'(in_data.ref_time);
  assign pot_add = {1'b0, pot_sum_r} + (SumW+1)'(in_data.pot_time);
  assign ref_sat = ref_add[SumW] ? SumMax : ref_add[SumW-1:0];
  assign pot_sat = pot_add[SumW] ? SumMax : pot_add[SumW-1:0];

  // shared subtractor; a zero divisor yields all-ones, i.e. saturated ratio
  assign trial = {rem_r, dvd_r[DvdW-1]};
  assign diff  = {1'b0, trial} - {2'b00, pot_sum_r[DivW-1:0]};

  assign ratio_q = (|dvd_r[DvdW-1:RatioW]) ? RatioMax : dvd_r[RatioW-1:0];
  assign gear_q  = gear_of(ratio_q);
  assign leds_q  = self_test_r ? leds_of(gear_q) : 2'b00;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire && cnt_r == CntLast) state_nxt = ST_MUL;
      end
      ST_MUL: begin
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (step_r == StepLast) state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    ref_sum_nxt   = ref_sum_r;
    pot_sum_nxt   = pot_sum_r;
    cnt_nxt       = cnt_r;
    step_nxt      = step_r;
    rem_nxt       = rem_r;
    dvd_nxt       = dvd_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (cnt_r == CntLast) begin
            cnt_nxt     = '0;
            ref_sum_nxt = ref_sat >> SeedShift;
            pot_sum_nxt = pot_sat >> SeedShift;
          end else begin
            cnt_nxt     = cnt_r + CntW'(1);
            ref_sum_nxt = ref_sat;
            pot_sum_nxt = pot_sat;
          end
        end
      end
      ST_MUL: begin
        dvd_nxt  = DvdW'(ref_sum_r[DivW-1:0]) * DvdW'(scale_r);
        rem_nxt  = '0;
        step_nxt = '0;
      end
      ST_DIV: begin
        step_nxt = step_r + StepW'(1);
        if (!diff[DivW+1]) begin
          rem_nxt = diff[DivW-1:0];
          dvd_nxt = {dvd_r[DvdW-2:0], 1'b1};
        end else begin
          rem_nxt = trial[DivW-1:0];
          dvd_nxt = {dvd_r[DvdW-2:0], 1'b0};
        end
      end
      ST_FIN: begin
        if (out_free) begin
          out_valid_nxt           = 1'b1;
          out_data_nxt.ratio      = ratio_q;
          out_data_nxt.gear       = gear_q;
          out_data_nxt.led_update = self_test_r;
          out_data_nxt.led_first  = leds_q[1];
          out_data_nxt.led_second = leds_q[0];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ref_sum_r   <= '0;
      pot_sum_r   <= '0;
      cnt_r       <= '0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
      scale_r     <= ScaleReset;
      self_test_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ref_sum_r   <= ref_sum_nxt;
      pot_sum_r   <= pot_sum_nxt;
      cnt_r       <= cnt_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          RegRatioScale: scale_r     <= cfg_data[ScaleW-1:0];
          RegSelfTest:   self_test_r <= cfg_data[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_r      <= rem_nxt;
    dvd_r      <= dvd_nxt;
    out_data_r <= out_data_nxt;
  end

  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DIV |-> step_r <= StepLast)
    else $error("divider step count out of range");

  a_mul_to_div: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_MUL |=> state_r == ST_DIV && step_r == '0)
    else $error("divide did not start from step zero");

  a_round_reset: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != ST_IDLE |-> cnt_r == '0)
    else $error("pair count not cleared while computing");

  a_gear_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_data_r.gear >= GearW'(1) && out_data_r.gear <= GearW'(NumFloors + 1))
    else $error("gear out of range");

  a_led_off: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_data_r.led_update |-> !out_data_r.led_first && !out_data_r.led_second)
    else $error("LED levels set with self-test off");

endmodule

`default_nettype wire
